[rtl/ddas_pkg.sv]
// Package for the decimal add / subtract / multiply core.
// Holds the item types, size constants and the divide-by-ten helper.
`default_nettype none
package ddas_pkg;

    // Operand digit limit and number of result digits that can be emitted.
    localparam int unsigned MAX_DIGITS = 24;
    localparam int unsigned RES_DEPTH  = 48;

    // Scratch digit width: holds 81 * 32 column sums plus an incoming carry.
    localparam int unsigned SCR_W = 12;

    // Operation codes.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic       operand;
        logic [3:0] digit;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [3:0] result_digit;
        logic       result_last;
        logic       too_long;
    } t_out_item;

    // Quotient by ten through a reciprocal multiply, exact below 43690.
    function automatic logic [SCR_W-1:0] div10(input logic [SCR_W-1:0] s);
        logic [27:0] p;
        p = 28'(s) * 28'd52429;
        return SCR_W'(p[27:19]);
    endfunction

endpackage
`default_nettype wire

[rtl/ddas_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module ddas_ram #(
    parameter int unsigned W  = 4,
    parameter int unsigned D  = 24,
    parameter int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/decimal_digit_add_sub_mul_core.sv]
// Decimal add / subtract / multiply core, top level. Uses ddas_pkg and ddas_ram.
// Load: one digit item per cycle; the closing second-operand item stalls the input.
// Then n scratch entries are cleared; each column step is a read then a write:
// n steps for add, n or 2n for subtract, fc*sc plus n for multiply, none for code 3;
// then setup; per digit a read, load and output state, held on output stall.
// Reset (synchronous, active low) clears counts, flags and the sequencer, not the RAMs.
`default_nettype none
module decimal_digit_add_sub_mul_core
    import ddas_pkg::*;
#(
    parameter int unsigned M = MAX_DIGITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam int unsigned AW  = (M > 1) ? $clog2(M) : 1;
    localparam int unsigned CW  = $clog2(M + 1);
    localparam int unsigned SD  = 2 * M + 2;
    localparam int unsigned SAW = $clog2(SD);

    typedef enum logic [3:0] {
        S_LOAD, S_CLEAR, S_ARD, S_AWR, S_MRD, S_MWR, S_CRD, S_CWR,
        S_ESET, S_ERD, S_ELD, S_EOUT
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_fc, r_sc;
    logic [1:0]       r_op;
    logic             r_busy, r_ovf, r_flag, r_pass, r_carry;
    logic [SAW-1:0]   r_i, r_j, r_len, r_k;
    logic [SCR_W-1:0] r_mc;
    logic             r_ovalid;
    t_out_item        r_out;

    logic             in_acc;
    logic [3:0]       dsat;
    logic             a_we, b_we, s_we;
    logic [AW-1:0]    a_raddr, b_raddr;
    logic [3:0]       a_rdata, b_rdata;
    logic [SAW-1:0]   s_waddr, s_raddr, n_len, b_pos, ij;
    logic [SCR_W-1:0] s_wdata, s_rdata;
    logic [SAW-1:0]   a_diff, b_diff;
    logic [3:0]       a_val, b_val, x_val, y_val, ad_dig;
    logic [4:0]       ad_sum;
    logic             ad_cout;
    logic [SCR_W-1:0] c_sum, c_q, c_r;
    logic [7:0]       prod;

    assign in_acc = i_in_valid && !o_in_stall;
    assign dsat   = (i_in_item.digit > 4'd9) ? 4'd9 : i_in_item.digit;
    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    // Digit count of the working result.
    always_comb begin
        if (r_op == OP_MUL) begin
            n_len = SAW'(r_fc) + SAW'(r_sc) + SAW'(1);
        end else begin
            n_len = ((r_fc > r_sc) ? SAW'(r_fc) : SAW'(r_sc)) + SAW'(1);
        end
    end

    // Operand stores are most significant first; map weight position to address.
    assign b_pos   = (r_state == S_MRD || r_state == S_MWR) ? r_j : r_i;
    assign a_diff  = SAW'(r_fc) - SAW'(1) - r_i;
    assign b_diff  = SAW'(r_sc) - SAW'(1) - b_pos;
    assign a_raddr = a_diff[AW-1:0];
    assign b_raddr = b_diff[AW-1:0];
    assign a_val   = (r_i < SAW'(r_fc)) ? a_rdata : 4'd0;
    assign b_val   = (b_pos < SAW'(r_sc)) ? b_rdata : 4'd0;
    assign ij      = r_i + r_j;

    // Add or subtract one digit column; the second subtract pass swaps operands.
    always_comb begin
        x_val   = r_pass ? b_val : a_val;
        y_val   = r_pass ? a_val : b_val;
        ad_sum  = 5'd0;
        ad_dig  = 4'd0;
        ad_cout = 1'b0;
        if (r_op == OP_ADD) begin
            ad_sum = 5'(a_val) + 5'(b_val) + 5'(r_carry);
            if (ad_sum >= 5'd10) begin
                ad_dig  = 4'(ad_sum - 5'd10);
                ad_cout = 1'b1;
            end else begin
                ad_dig = ad_sum[3:0];
            end
        end else begin
            ad_sum = 5'(y_val) + 5'(r_carry);
            if (5'(x_val) < ad_sum) begin
                ad_dig  = 4'(5'(x_val) + 5'd10 - ad_sum);
                ad_cout = 1'b1;
            end else begin
                ad_dig = 4'(5'(x_val) - ad_sum);
            end
        end
    end

    // Multiply partial product and carry normalization.
    assign prod  = 8'(a_val) * 8'(b_val);
    assign c_sum = s_rdata + r_mc;
    assign c_q   = div10(c_sum);
    assign c_r   = c_sum - SCR_W'(c_q * SCR_W'(10));

    // Scratch RAM port selection.
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_i;
        s_wdata = '0;
        s_raddr = r_i;
        case (r_state)
            S_CLEAR: begin
                s_we = 1'b1;
            end
            S_AWR: begin
                s_we    = 1'b1;
                s_wdata = SCR_W'(ad_dig);
            end
            S_MRD: begin
                s_raddr = ij;
            end
            S_MWR: begin
                s_we    = 1'b1;
                s_waddr = ij;
                s_wdata = s_rdata + SCR_W'(prod);
            end
            S_CWR: begin
                s_we    = 1'b1;
                s_wdata = c_r;
            end
            S_ERD: begin
                s_raddr = r_k;
            end
            default: begin
            end
        endcase
    end

    assign a_we = in_acc && !i_in_item.operand && (r_fc < CW'(M));
    assign b_we = in_acc && i_in_item.operand && (r_sc < CW'(M));

    ddas_ram #(.W(4), .D(M), .AW(AW)) u_first (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(r_fc[AW-1:0]), .i_wdata(dsat),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    ddas_ram #(.W(4), .D(M), .AW(AW)) u_second (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(r_sc[AW-1:0]), .i_wdata(dsat),
        .i_raddr(b_raddr), .o_rdata(b_rdata)
    );

    ddas_ram #(.W(SCR_W), .D(SD), .AW(SAW)) u_scratch (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    // Sequencer: loading, column loops, carry pass and result emission.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_fc     <= '0;
            r_sc     <= '0;
            r_op     <= OP_ADD;
            r_busy   <= 1'b0;
            r_ovf    <= 1'b0;
            r_flag   <= 1'b0;
            r_pass   <= 1'b0;
            r_carry  <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_len    <= '0;
            r_k      <= '0;
            r_mc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (!r_busy) begin
                            r_op   <= i_in_item.operation;
                            r_busy <= 1'b1;
                        end
                        if (a_we) begin
                            r_fc <= r_fc + CW'(1);
                        end else if (b_we) begin
                            r_sc <= r_sc + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in_item.operand && i_in_item.last) begin
                            r_i     <= '0;
                            r_state <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR: begin
                    r_i     <= r_i + SAW'(1);
                    r_j     <= '0;
                    r_pass  <= 1'b0;
                    r_carry <= 1'b0;
                    r_mc    <= '0;
                    r_len   <= SAW'(1);
                    if (r_i == n_len - SAW'(1)) begin
                        r_i <= '0;
                        if (r_op == OP_ADD || r_op == OP_SUB) begin
                            r_state <= S_ARD;
                        end else if (r_op == OP_MUL) begin
                            r_state <= (r_fc == '0 || r_sc == '0) ? S_CRD : S_MRD;
                        end else begin
                            r_fc    <= '0;
                            r_sc    <= '0;
                            r_ovf   <= 1'b0;
                            r_busy  <= 1'b0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_ARD: begin
                    r_state <= S_AWR;
                end
                S_AWR: begin
                    r_carry <= ad_cout;
                    if (ad_dig != 4'd0) begin
                        r_len <= r_i + SAW'(1);
                    end
                    r_i     <= r_i + SAW'(1);
                    r_state <= S_ARD;
                    if (r_i == n_len - SAW'(1)) begin
                        if (r_op == OP_SUB && !r_pass && ad_cout) begin
                            r_pass  <= 1'b1;
                            r_carry <= 1'b0;
                            r_i     <= '0;
                            r_len   <= SAW'(1);
                        end else begin
                            r_state <= S_ESET;
                        end
                    end
                end
                S_MRD: begin
                    r_state <= S_MWR;
                end
                S_MWR: begin
                    r_state <= S_MRD;
                    r_j     <= r_j + SAW'(1);
                    if (r_j == SAW'(r_sc) - SAW'(1)) begin
                        r_j <= '0;
                        r_i <= r_i + SAW'(1);
                        if (r_i == SAW'(r_fc) - SAW'(1)) begin
                            r_i     <= '0;
                            r_state <= S_CRD;
                        end
                    end
                end
                S_CRD: begin
                    r_state <= S_CWR;
                end
                S_CWR: begin
                    r_mc <= c_q;
                    if (c_r != '0) begin
                        r_len <= r_i + SAW'(1);
                    end
                    r_i     <= r_i + SAW'(1);
                    r_state <= (r_i == n_len - SAW'(1)) ? S_ESET : S_CRD;
                end
                S_ESET: begin
                    if (32'(r_len) > RES_DEPTH) begin
                        r_k    <= SAW'(RES_DEPTH - 1);
                        r_flag <= 1'b1;
                    end else begin
                        r_k    <= r_len - SAW'(1);
                        r_flag <= r_ovf;
                    end
                    r_fc    <= '0;
                    r_sc    <= '0;
                    r_ovf   <= 1'b0;
                    r_busy  <= 1'b0;
                    r_state <= S_ERD;
                end
                S_ERD: begin
                    r_state <= S_ELD;
                end
                S_ELD: begin
                    r_out.result_digit <= s_rdata[3:0];
                    r_out.result_last  <= (r_k == '0);
                    r_out.too_long     <= r_flag;
                    r_ovalid           <= 1'b1;
                    r_state            <= S_EOUT;
                end
                S_EOUT: begin
                    if (!i_out_stall) begin
                        r_ovalid <= 1'b0;
                        if (r_k == '0) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k - SAW'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[tb/decimal_digit_add_sub_mul_checker.sv]
// Checker for the decimal add / subtract / multiply core: predicts result digits.
// Depends on ddas_pkg for the item types and size limits.
`timescale 1ns / 100ps
module decimal_digit_add_sub_mul_checker
    import ddas_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_item,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_result_count
);

    logic [3:0] first_num[MAX_DIGITS];
    logic [3:0] second_num[MAX_DIGITS];
    int unsigned first_len, second_len;
    logic [1:0] latched_op;
    logic        truncated, busy;
    t_out_item   digit_queue[$];

    // Digit of weight 10^pos of a number stored most significant first.
    function automatic int unsigned weight_digit(input logic [3:0] num[MAX_DIGITS],
                                                 input int unsigned len,
                                                 input int unsigned pos);
        if (pos >= len) return 0;
        return num[len - 1 - pos];
    endfunction

    // Runs the calculation and queues the expected result digits.
    task automatic compute_digits();
        int unsigned w[2 * MAX_DIGITS + 2];
        int unsigned n, len, carry, s, x, y, borrow;
        bit flag, swap;
        t_out_item r;
        foreach (w[i]) w[i] = 0;
        n = (first_len > second_len ? first_len : second_len) + 1;
        flag = truncated;
        if (latched_op == OP_ADD) begin
            carry = 0;
            for (int i = 0; i < n; i++) begin
                s = weight_digit(first_num, first_len, i)
                    + weight_digit(second_num, second_len, i) + carry;
                w[i] = s % 10;
                carry = s / 10;
            end
        end else if (latched_op == OP_SUB) begin
            // Try a-b; on final borrow do b-a instead.
            for (int pass = 0; pass < 2; pass++) begin
                swap = (pass == 1);
                borrow = 0;
                for (int i = 0; i < n; i++) begin
                    x = swap ? weight_digit(second_num, second_len, i)
                             : weight_digit(first_num, first_len, i);
                    y = (swap ? weight_digit(first_num, first_len, i)
                              : weight_digit(second_num, second_len, i)) + borrow;
                    if (x < y) begin
                        w[i] = x + 10 - y;
                        borrow = 1;
                    end else begin
                        w[i] = x - y;
                        borrow = 0;
                    end
                end
                if (borrow == 0) break;
            end
        end else if (latched_op == OP_MUL) begin
            n = first_len + second_len + 1;
            for (int i = 0; i < first_len; i++)
                for (int j = 0; j < second_len; j++)
                    w[i + j] += weight_digit(first_num, first_len, i)
                                * weight_digit(second_num, second_len, j);
            carry = 0;
            for (int i = 0; i < n; i++) begin
                s = w[i] + carry;
                w[i] = s % 10;
                carry = s / 10;
            end
        end else begin
            n = 0;
        end
        first_len = 0;
        second_len = 0;
        truncated = 0;
        busy = 0;
        if (n == 0) return;
        len = 1;
        for (int i = 0; i < n; i++)
            if (w[i] != 0) len = i + 1;
        if (len > RES_DEPTH) begin
            len = RES_DEPTH;
            flag = 1;
        end
        for (int i = len - 1; i >= 0; i--) begin
            r.result_digit = w[i][3:0];
            r.result_last = (i == 0);
            r.too_long = flag;
            digit_queue.push_back(r);
        end
    endtask

    // Model each accepted input item.
    always @(posedge i_clk) begin
        logic [3:0] d;
        if (!i_rst_n) begin
            first_len = 0;
            second_len = 0;
            latched_op = OP_ADD;
            truncated = 0;
            busy = 0;
        end else if (i_in_valid && !i_in_stall) begin
            d = (i_in_item.digit > 9) ? 4'd9 : i_in_item.digit;
            if (!busy) begin
                latched_op = i_in_item.operation;
                busy = 1;
            end
            if (!i_in_item.operand) begin
                if (first_len < MAX_DIGITS) first_num[first_len++] = d;
                else truncated = 1;
            end else begin
                if (second_len < MAX_DIGITS) second_num[second_len++] = d;
                else truncated = 1;
            end
            if (i_in_item.operand && i_in_item.last) compute_digits();
        end
    end

    // Compare each accepted result item with the oldest expectation.
    initial o_fail_count = 0;
    initial o_result_count = 0;
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            o_result_count++;
            if (digit_queue.size() == 0) begin
                $error("Result item with no expectation: %p", i_out_item);
                o_fail_count++;
            end else begin
                e = digit_queue.pop_front();
                if (e.result_digit !== i_out_item.result_digit) begin
                    $error("result_digit: expected %0d, got %0d",
                           e.result_digit, i_out_item.result_digit);
                    o_fail_count++;
                end
                if (e.result_last !== i_out_item.result_last) begin
                    $error("result_last: expected %0d, got %0d",
                           e.result_last, i_out_item.result_last);
                    o_fail_count++;
                end
                if (e.too_long !== i_out_item.too_long) begin
                    $error("too_long: expected %0d, got %0d",
                           e.too_long, i_out_item.too_long);
                    o_fail_count++;
                end
            end
        end
    end

    assign o_pending = digit_queue.size();

endmodule

[tb/decimal_digit_add_sub_mul_core_tb.sv]
// Testbench top for the decimal add / subtract / multiply core.
// Drives digit items with random idling; depends on ddas_pkg and the checker module.
`timescale 1ns / 100ps
module decimal_digit_add_sub_mul_core_tb;
    import ddas_pkg::*;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      in_valid = 0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 0;
    t_out_item out_item;
    int        fail_count, pending, result_count;
    int        send_idle_pct = 0, recv_stall_pct = 0;
    int        items_sent = 0, calcs_sent = 0;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    decimal_digit_add_sub_mul_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item)
    );

    decimal_digit_add_sub_mul_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // Receiver stalls at random, per the current phase.
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Send one digit item, with optional idle cycles before it.
    task automatic send_digit(input logic [1:0] op, input logic which,
                              input logic [3:0] d, input logic lst);
        t_in_item it;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        it.operation = op;
        it.operand = which;
        it.digit = d;
        it.last = lst;
        in_item <= it;
        in_valid <= 1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Send a full calculation; digits are random unless fixed is set.
    task automatic send_calc(input logic [1:0] op, input int alen, input int blen,
                             input int fixed);
        logic [3:0] d;
        for (int i = 0; i < alen; i++) begin
            d = (fixed >= 0) ? 4'(fixed) : 4'($urandom_range(15));
            send_digit((i == 0) ? op : 2'($urandom), 0, d, (i == alen - 1));
        end
        for (int i = 0; i < blen; i++) begin
            d = (fixed >= 0) ? 4'(fixed) : 4'($urandom_range(15));
            send_digit((i == 0 && alen == 0) ? op : 2'($urandom), 1, d, (i == blen - 1));
        end
        calcs_sent++;
    endtask

    initial begin
        int alen, blen, sel;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: each operation, extremes, overlong operands, code 3.
        send_calc(OP_ADD, 1, 1, 0);
        send_calc(OP_SUB, 2, 2, 9);
        send_calc(OP_MUL, 24, 24, 9);
        send_calc(OP_ADD, 24, 24, 9);
        send_calc(OP_SUB, 0, 3, 5);
        send_calc(OP_MUL, 26, 2, 15);
        send_calc(2'd3, 2, 2, 7);
        send_calc(OP_SUB, 3, 1, 0);

        // Random phases of idling.
        for (int k = 0; k < 36; k++) begin
            case (k / 9)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            sel = $urandom_range(19);
            alen = (sel == 0) ? $urandom_range(26, 20) : $urandom_range(3);
            blen = (sel == 1) ? $urandom_range(26, 20) : $urandom_range(3, 1);
            send_calc(2'($urandom_range(3)), alen, blen, -1);
        end
        in_valid <= 0;

        // Drain, then a short quiet tail.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d input items in %0d calculations, %0d result digits.",
                 items_sent, calcs_sent, result_count);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
rtl/ddas_pkg.sv
rtl/ddas_ram.sv
rtl/decimal_digit_add_sub_mul_core.sv
tb/decimal_digit_add_sub_mul_checker.sv
tb/decimal_digit_add_sub_mul_core_tb.sv
